// ===== rtl/v3n_pkg.sv =====
// Package for the 3D vector length and normalise block.
// Holds the default sizes; used by vector3_length_normalize and v3n_core.
`timescale 1ns / 1ps
package v3n_pkg;
  localparam int COMP_WIDTH_DEF     = 32;
  localparam int IN_FRAC_BITS_DEF   = 16;
  localparam int UNIT_FRAC_BITS_DEF = 30;
endpackage

// ===== rtl/v3n_core.sv =====
// Pipelined datapath: squares, bit-serial root stages, restoring divider stages.
// Depends on v3n_pkg.
`timescale 1ns / 1ps
module v3n_core import v3n_pkg::*; #(
  parameter int COMP_WIDTH     = COMP_WIDTH_DEF,
  parameter int UNIT_FRAC_BITS = UNIT_FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         adv,
  input  logic                         in_v,
  input  logic [COMP_WIDTH-1:0]        x,
  input  logic [COMP_WIDTH-1:0]        y,
  input  logic [COMP_WIDTH-1:0]        z,
  output logic                         o_v,
  output logic [COMP_WIDTH-1:0]        o_len,
  output logic [UNIT_FRAC_BITS+1:0]    o_ux,
  output logic [UNIT_FRAC_BITS+1:0]    o_uy,
  output logic [UNIT_FRAC_BITS+1:0]    o_uz,
  output logic                         o_zero
);
  localparam int W  = COMP_WIDTH;
  localparam int SW = 2 * W + 2;
  localparam int NW = W + UNIT_FRAC_BITS;
  localparam int UW = UNIT_FRAC_BITS + 2;
  localparam int NS = 2 + W + NW;

  logic          v_r    [NS];
  logic [SW-1:0] sum_r  [NS];
  logic [W-1:0]  root_r [NS];
  logic [W:0]    rem_r  [NS];
  logic [W-1:0]  mag_r  [NS][3];
  logic          neg_r  [NS][3];
  logic [W:0]    drem_r [NS][3];
  logic [NW-1:0] q_r    [NS][3];
  logic [2*W-1:0] sq    [3];

  // Magnitudes; the most negative value wraps to its correct unsigned magnitude.
  logic [W-1:0] mag_nxt [3];
  always_comb begin
    mag_nxt[0] = x[W-1] ? (~x + 1'b1) : x;
    mag_nxt[1] = y[W-1] ? (~y + 1'b1) : y;
    mag_nxt[2] = z[W-1] ? (~z + 1'b1) : z;
  end

  // Full-width squares of the registered magnitudes.
  always_comb begin
    for (int c = 0; c < 3; c++) sq[c] = mag_r[0][c] * mag_r[0][c];
  end

  // Stage 0 registers magnitudes; stage 1 forms the sum of squares.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NS; s++) v_r[s] <= 1'b0;
    end else if (adv) begin
      v_r[0] <= in_v;
      for (int s = 1; s < NS; s++) v_r[s] <= v_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < 3; c++) begin
        mag_r[0][c] <= mag_nxt[c];
        neg_r[0][c] <= (c == 0) ? x[W-1] : (c == 1) ? y[W-1] : z[W-1];
      end
      sum_r[1] <= SW'(sq[0]) + SW'(sq[1]) + SW'(sq[2]);
      root_r[1] <= '0;
      rem_r[1]  <= '0;
      for (int c = 0; c < 3; c++) begin
        mag_r[1][c] <= mag_r[0][c];
        neg_r[1][c] <= neg_r[0][c];
      end
    end
  end

  // Root: one result bit per stage, non-restoring-free restoring scheme.
  genvar g;
  generate
    for (g = 0; g < W; g++) begin : g_root
      localparam int S = 2 + g;
      logic [W+2:0] trial;
      logic [W+2:0] rw;
      always_comb begin
        rw    = {rem_r[S-1][W:0], sum_r[S-1][SW-1-2*g-2 -: 2]};
        trial = {1'b0, root_r[S-1], 2'b01};
      end
      always_ff @(posedge clk) begin
        if (adv) begin
          sum_r[S] <= sum_r[S-1];
          if (rw >= trial) begin
            rem_r[S]  <= (W+1)'(rw - trial);
            root_r[S] <= {root_r[S-1][W-2:0], 1'b1};
          end else begin
            rem_r[S]  <= (W+1)'(rw);
            root_r[S] <= {root_r[S-1][W-2:0], 1'b0};
          end
          for (int c = 0; c < 3; c++) begin
            mag_r[S][c] <= mag_r[S-1][c];
            neg_r[S][c] <= neg_r[S-1][c];
            drem_r[S][c] <= '0;
            q_r[S][c]    <= '0;
          end
        end
      end
    end
    // Divider: one quotient bit per stage for each component.
    for (g = 0; g < NW; g++) begin : g_div
      localparam int S = 2 + W + g;
      always_ff @(posedge clk) begin
        logic [W+1:0] r;
        logic [NW-1:0] num;
        if (adv) begin
          sum_r[S]  <= sum_r[S-1];
          root_r[S] <= root_r[S-1];
          rem_r[S]  <= rem_r[S-1];
          for (int c = 0; c < 3; c++) begin
            num = NW'({mag_r[S-1][c], {UNIT_FRAC_BITS{1'b0}}});
            r   = {drem_r[S-1][c], num[NW-1-g]};
            mag_r[S][c] <= mag_r[S-1][c];
            neg_r[S][c] <= neg_r[S-1][c];
            if (r >= {2'b00, root_r[S-1]}) begin
              drem_r[S][c] <= (W+1)'(r - {2'b00, root_r[S-1]});
              q_r[S][c]    <= {q_r[S-1][c][NW-2:0], 1'b1};
            end else begin
              drem_r[S][c] <= (W+1)'(r);
              q_r[S][c]    <= {q_r[S-1][c][NW-2:0], 1'b0};
            end
          end
        end
      end
    end
  endgenerate

  logic zr;
  assign zr     = (root_r[NS-1] == '0);
  assign o_v    = v_r[NS-1];
  assign o_len  = root_r[NS-1];
  assign o_zero = zr;
  assign o_ux = zr ? '0 : neg_r[NS-1][0] ? UW'(-q_r[NS-1][0]) : UW'(q_r[NS-1][0]);
  assign o_uy = zr ? '0 : neg_r[NS-1][1] ? UW'(-q_r[NS-1][1]) : UW'(q_r[NS-1][1]);
  assign o_uz = zr ? '0 : neg_r[NS-1][2] ? UW'(-q_r[NS-1][2]) : UW'(q_r[NS-1][2]);
endmodule

// ===== rtl/vector3_length_normalize.sv =====
// Top level of the 3D vector length and normalise block, with output register.
// Depends on v3n_pkg and v3n_core.
`timescale 1ns / 1ps
// Usage: one vector beat enters on the in_ channel per cycle while in_ready is
// high (in_valid/in_ready). Each beat gives one result beat on the out_ channel:
// the floor square root length in the input format, the unit vector in Q2.30
// and a zero flag. The pipeline is followed by the output register: the root and
// the divider each resolve one bit per stage. Throughput is one beat per cycle
// when the receiver does not stall.
// Reset clears every valid bit; payload registers are not reset.
// When the receiver stalls, the whole pipeline holds while the output register
// is full, so nothing is lost or repeated; in_ready falls with it.
// The zero vector gives length zero, zero components and zero_vector high.
module vector3_length_normalize import v3n_pkg::*; #(
  parameter int COMP_WIDTH     = COMP_WIDTH_DEF,
  parameter int UNIT_FRAC_BITS = UNIT_FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [COMP_WIDTH-1:0]      in_x_in,
  input  logic signed [COMP_WIDTH-1:0]      in_y_in,
  input  logic signed [COMP_WIDTH-1:0]      in_z_in,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [COMP_WIDTH-1:0]             out_length_out,
  output logic signed [UNIT_FRAC_BITS+1:0]  out_unit_x,
  output logic signed [UNIT_FRAC_BITS+1:0]  out_unit_y,
  output logic signed [UNIT_FRAC_BITS+1:0]  out_unit_z,
  output logic                              out_zero_vector
);
  localparam int UW = UNIT_FRAC_BITS + 2;
  logic adv, pv, pz;
  logic [COMP_WIDTH-1:0] pl;
  logic [UW-1:0] px, py, pzc;
  logic out_valid_r;

  // The pipeline moves whenever the output register can take its last stage.
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  v3n_core #(.COMP_WIDTH(COMP_WIDTH), .UNIT_FRAC_BITS(UNIT_FRAC_BITS)) u_core (
    .clk(clk), .rst_n(rst_n), .adv(adv), .in_v(in_valid),
    .x(in_x_in), .y(in_y_in), .z(in_z_in),
    .o_v(pv), .o_len(pl), .o_ux(px), .o_uy(py), .o_uz(pzc), .o_zero(pz)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= pv;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_length_out  <= pl;
      out_unit_x      <= px;
      out_unit_y      <= py;
      out_unit_z      <= pzc;
      out_zero_vector <= pz;
    end
  end

  assign out_valid = out_valid_r;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r && $stable(out_length_out))
    else $error("result changed while stalled");
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_zero_vector |-> out_length_out == '0 && out_unit_x == '0)
    else $error("zero flag inconsistent");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ready)
    else $error("stall without full output");
endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for vector3_length_normalize: a directed table, then random vectors.
// Depends on v3n_pkg and the block RTL; checks results against the table or an in-line predictor.
`timescale 1ns / 1ps
module tb import v3n_pkg::*; ();

  localparam int CW = COMP_WIDTH_DEF;
  localparam int UF = UNIT_FRAC_BITS_DEF;
  localparam int UW = UF + 2;
  // Pipeline depth: the core's stages plus the output register.
  localparam int PIPE_DEPTH = 2 + CW + CW + UF + 1;
  localparam int N_RANDOM = 530;

  typedef struct packed {
    logic [CW-1:0] length;
    logic [UW-1:0] ux;
    logic [UW-1:0] uy;
    logic [UW-1:0] uz;
    logic          zero;
  } norm_t;

  typedef struct {
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic [CW-1:0] z;
    bit            typed;
    norm_t         res;
  } vec_row_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic signed [CW-1:0] in_x_in, in_y_in, in_z_in;
  logic out_valid;
  logic out_ready;
  logic [CW-1:0] out_length_out;
  logic signed [UW-1:0] out_unit_x, out_unit_y, out_unit_z;
  logic out_zero_vector;

  norm_t expected_norms[$];
  int mismatches = 0;
  int cyc;

  vector3_length_normalize u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_x_in(in_x_in), .in_y_in(in_y_in), .in_z_in(in_z_in),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_length_out(out_length_out),
    .out_unit_x(out_unit_x), .out_unit_y(out_unit_y), .out_unit_z(out_unit_z),
    .out_zero_vector(out_zero_vector)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Magnitude of a two's complement component; the most negative value gives 2^(CW-1).
  function automatic logic [63:0] comp_mag(input logic [CW-1:0] v);
    if (v[CW-1]) return 64'((~v) + 1'b1) & ((64'd1 << CW) - 1);
    return 64'(v);
  endfunction

  // Floor square root of the exact sum of squares, then each magnitude scaled
  // by 2^UF and divided by the length, truncated toward zero, sign restored.
  function automatic norm_t normalise(input logic [CW-1:0] x, input logic [CW-1:0] y,
                                      input logic [CW-1:0] z);
    logic [63:0] mx, my, mz, sumsq, root, trial, q;
    norm_t r;
    mx = comp_mag(x);
    my = comp_mag(y);
    mz = comp_mag(z);
    sumsq = mx * mx + my * my + mz * mz;
    root = 0;
    for (int i = CW; i >= 0; i--) begin
      trial = root | (64'd1 << i);
      if (trial * trial <= sumsq && trial < (64'd1 << CW)) root = trial;
    end
    r.length = root[CW-1:0];
    r.zero = (root == 0);
    r.ux = '0;
    r.uy = '0;
    r.uz = '0;
    if (root != 0) begin
      q = (mx << UF) / root;
      r.ux = x[CW-1] ? UW'(-q) : UW'(q);
      q = (my << UF) / root;
      r.uy = y[CW-1] ? UW'(-q) : UW'(q);
      q = (mz << UF) / root;
      r.uz = z[CW-1] ? UW'(-q) : UW'(q);
    end
    return r;
  endfunction

  // Drives one beat and holds it until accepted; in_valid is left high so the
  // caller either sends the next beat or lowers it in the same step.
  task automatic send_vector(input logic [CW-1:0] x, input logic [CW-1:0] y,
                             input logic [CW-1:0] z, input bit typed, input norm_t res);
    norm_t pred;
    in_valid <= 1'b1;
    in_x_in <= x;
    in_y_in <= y;
    in_z_in <= z;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred = normalise(x, y, z);
    if (typed && pred != res)
      $display("Table row disagrees with prediction for %h %h %h", x, y, z);
    expected_norms.push_back(typed ? res : pred);
  endtask

  function automatic logic [CW-1:0] rand_comp();
    case ($urandom_range(0, 9))
      0: return {1'b1, {(CW-1){1'b0}}};
      1: return {1'b0, {(CW-1){1'b1}}};
      2: return '0;
      3: return CW'($signed($urandom_range(0, 64)) - 32);
      4: return CW'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      default: return CW'($urandom);
    endcase
  endfunction

  // Receiver: compares each accepted result beat with the oldest expected result and
  // stalls in phases of its own: always ready, coin-toss, or long holds.
  always @(posedge clk) begin
    norm_t got, exp_r;
    if (!rst_n) begin
      out_ready <= 1'b0;
      cyc <= 0;
    end else begin
      cyc <= cyc + 1;
      if (out_valid && out_ready) begin
        got = '{out_length_out, out_unit_x, out_unit_y, out_unit_z, out_zero_vector};
        if (expected_norms.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Result beat with nothing expected: %p", got);
        end else begin
          exp_r = expected_norms.pop_front();
          if (got != exp_r) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Mismatch: expected %p, got %p", exp_r, got);
          end
        end
      end
      case ((cyc / 97) % 3)
        0: out_ready <= 1'b1;
        1: out_ready <= $urandom_range(0, 1);
        default: out_ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  initial begin
    vec_row_t rows[$];
    norm_t none;
    int burst;
    int waited;
    logic [CW-1:0] mn, mx_pos;
    none = '{default: '0};
    mn = {1'b1, {(CW-1){1'b0}}};
    mx_pos = {1'b0, {(CW-1){1'b1}}};
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_x_in = '0;
    in_y_in = '0;
    in_z_in = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The zero vector leaves the components unscaled and raises the flag.
    rows.push_back('{'0, '0, '0, 1'b1, '{'0, '0, '0, '0, 1'b1}});
    // A lone most negative component: length 2^(CW-1), unit component minus one.
    rows.push_back('{mn, '0, '0, 1'b1, '{32'h8000_0000, 32'hC000_0000, '0, '0, 1'b0}});
    rows.push_back('{'0, mn, '0, 1'b1, '{32'h8000_0000, '0, 32'hC000_0000, '0, 1'b0}});
    rows.push_back('{'0, '0, mn, 1'b1, '{32'h8000_0000, '0, '0, 32'hC000_0000, 1'b0}});
    // Smallest nonzero length and the largest positive value: unit component exactly plus or minus one.
    rows.push_back('{32'd1, '0, '0, 1'b1, '{32'd1, 32'h4000_0000, '0, '0, 1'b0}});
    rows.push_back('{'0, '1, '0, 1'b1, '{32'd1, '0, 32'hC000_0000, '0, 1'b0}});
    rows.push_back('{mx_pos, '0, '0, 1'b1, '{mx_pos, 32'h4000_0000, '0, '0, 1'b0}});
    // All three at the extremes, up to the largest sum of squares, then mixed vectors.
    rows.push_back('{mn, mn, mn, 1'b0, none});
    rows.push_back('{mx_pos, mx_pos, mx_pos, 1'b0, none});
    rows.push_back('{mn, mx_pos, mn, 1'b0, none});
    rows.push_back('{32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 1'b0, none});
    rows.push_back('{32'h0003_0000, 32'h0004_0000, '0, 1'b0, none});
    rows.push_back('{'1, '1, '1, 1'b0, none});
    rows.push_back('{32'd1, 32'd1, '0, 1'b0, none});
    rows.push_back('{32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F, 1'b0, none});

    foreach (rows[i]) send_vector(rows[i].x, rows[i].y, rows[i].z, rows[i].typed, rows[i].res);

    // Random vectors in bursts, with an idle gap after most bursts.
    burst = $urandom_range(1, 20);
    for (int n = 0; n < N_RANDOM; n++) begin
      send_vector(rand_comp(), rand_comp(), rand_comp(), 1'b0, none);
      burst--;
      if (burst == 0) begin
        burst = $urandom_range(1, 20);
        if ($urandom_range(0, 3) != 0) begin
          in_valid <= 1'b0;
          repeat ($urandom_range(1, 12)) @(posedge clk);
        end
      end
    end
    in_valid <= 1'b0;

    waited = 0;
    while (expected_norms.size() != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (PIPE_DEPTH + 20) @(posedge clk);

    if (mismatches == 0 && expected_norms.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end
endmodule
